@@ src/gcw_pkg.sv @@
// Shared widths, request and status codes, and controller/datapath signal groups.
package gcw_pkg;

    localparam int unsigned TYPE_W  = 2;
    localparam int unsigned GROUP_W = 8;
    localparam int unsigned SPG_W   = 4;
    localparam int unsigned GIU_W   = 9;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned TOTAL_W = 16;
    localparam int unsigned TABLE_DEPTH = 256;

    localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FILE   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd1;
    localparam logic [STAT_W-1:0] ST_LAST_NZ  = 2'd2;

    typedef struct packed {
        logic load;
        logic wr_en;
        logic rd_en;
        logic step;
        logic take_link;
        logic add_last;
        logic set_over;
        logic set_end;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pos_eq_last;
        logic pos_zero;
        logic at_bound;
        logic out_free;
    } t_sts;

endpackage

@@ src/gcw_req_if.sv @@
// Request channel: valid/ready handshake with the request fields.
interface gcw_req_if;
    logic                              valid;
    logic                              ready;
    logic [gcw_pkg::TYPE_W-1:0]        req_type;
    logic [gcw_pkg::GROUP_W-1:0]       entry_index;
    logic [gcw_pkg::GROUP_W-1:0]       entry_value;
    logic [gcw_pkg::GROUP_W-1:0]       first_group;
    logic [gcw_pkg::GROUP_W-1:0]       last_group;
    logic [gcw_pkg::GROUP_W-1:0]       last_sector_index;

    modport source (
        output valid, req_type, entry_index, entry_value, first_group, last_group,
               last_sector_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_value, first_group, last_group,
               last_sector_index,
        output ready
    );
endinterface

@@ src/gcw_rsp_if.sv @@
// Result channel: valid/ready handshake with the result fields.
interface gcw_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [gcw_pkg::COUNT_W-1:0]       sector_count;
    logic [gcw_pkg::STAT_W-1:0]        chain_status;
    logic [gcw_pkg::TOTAL_W-1:0]       used_sectors_total;

    modport source (
        output valid, sector_count, chain_status, used_sectors_total,
        input  ready
    );
    modport sink (
        input  valid, sector_count, chain_status, used_sectors_total,
        output ready
    );
endinterface

@@ src/gcw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gcw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/gcw_ctrl.sv @@
// Request sequencer: accepts a request, steps the chain walk, hands off the result.
module gcw_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic [gcw_pkg::TYPE_W-1:0] i_req_type,
    input  gcw_pkg::t_sts              i_sts,
    output logic                       o_req_ready,
    output gcw_pkg::t_cmd              o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FCHK   = 3'd1;
    localparam logic [2:0] S_ZSTART = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_ZCHK   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_free;
    logic       n_free;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_free  = r_free;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        gcw_pkg::REQ_WRITE: begin
                            o_cmd.wr_en = 1'b1;
                            n_state     = S_DONE;
                        end
                        gcw_pkg::REQ_FILE: begin
                            n_free  = 1'b0;
                            n_state = S_FCHK;
                        end
                        gcw_pkg::REQ_FREE: begin
                            n_free  = 1'b1;
                            n_state = S_ZSTART;
                        end
                        gcw_pkg::REQ_UNUSED: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FCHK: begin
                priority if (i_sts.pos_eq_last) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FIN;
                end else if (i_sts.at_bound) begin
                    o_cmd.set_over = 1'b1;
                    o_cmd.add_last = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.step  = 1'b1;
                    n_state     = S_WAIT;
                end
            end
            S_ZSTART: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.take_link = 1'b1;
                n_state         = r_free ? S_ZCHK : S_FCHK;
            end
            S_ZCHK: begin
                priority if (i_sts.pos_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.at_bound) begin
                    o_cmd.set_over = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.step  = 1'b1;
                    n_state     = S_WAIT;
                end
            end
            S_FIN: begin
                o_cmd.set_end  = 1'b1;
                o_cmd.add_last = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
        end
    end

`ifndef SYNTHESIS
    a_fin_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_FCHK))
        else $error("final check entered without a table read");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("result not handed off with free output slot");
`endif

endmodule

@@ src/gcw_dp.sv @@
// Walk datapath: link table, position and count registers, result register, used total.
module gcw_dp #(
    parameter int unsigned MAX_GROUPS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gcw_pkg::t_cmd               i_cmd,
    output gcw_pkg::t_sts               o_sts,
    input  logic [gcw_pkg::TYPE_W-1:0]  i_req_type,
    input  logic [gcw_pkg::GROUP_W-1:0] i_entry_index,
    input  logic [gcw_pkg::GROUP_W-1:0] i_entry_value,
    input  logic [gcw_pkg::GROUP_W-1:0] i_first_group,
    input  logic [gcw_pkg::GROUP_W-1:0] i_last_group,
    input  logic [gcw_pkg::GROUP_W-1:0] i_last_sector_index,
    input  logic [gcw_pkg::SPG_W-1:0]   i_sectors_per_group,
    input  logic [gcw_pkg::GIU_W-1:0]   i_groups_in_use,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [gcw_pkg::COUNT_W-1:0] o_sector_count,
    output logic [gcw_pkg::STAT_W-1:0]  o_chain_status,
    output logic [gcw_pkg::TOTAL_W-1:0] o_used_sectors_total
);

    localparam int unsigned LINK_W = $clog2(MAX_GROUPS + 1);
    localparam logic [gcw_pkg::GIU_W-1:0] MAX_BOUND = gcw_pkg::GIU_W'(MAX_GROUPS);

    logic [gcw_pkg::GROUP_W-1:0] r_pos;
    logic [gcw_pkg::GROUP_W-1:0] r_last;
    logic [gcw_pkg::GROUP_W-1:0] r_lsi;
    logic                        r_is_file;
    logic [LINK_W-1:0]           r_links;
    logic [gcw_pkg::COUNT_W-1:0] r_count;
    logic [gcw_pkg::STAT_W-1:0]  r_status;
    logic [gcw_pkg::TOTAL_W-1:0] r_used;
    logic                        r_out_valid;
    logic [gcw_pkg::COUNT_W-1:0] r_out_count;
    logic [gcw_pkg::STAT_W-1:0]  r_out_status;
    logic [gcw_pkg::TOTAL_W-1:0] r_out_total;

    logic [gcw_pkg::GROUP_W-1:0] rd_data;
    logic [gcw_pkg::GIU_W-1:0]   bound;
    logic [gcw_pkg::GIU_W-1:0]   links_ext;
    logic [gcw_pkg::COUNT_W:0]   count_step;
    logic [gcw_pkg::TOTAL_W-1:0] used_next;

    gcw_ram #(
        .WIDTH (gcw_pkg::GROUP_W),
        .DEPTH (gcw_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_entry_index),
        .i_wr_data (i_entry_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data)
    );

    assign bound      = (i_groups_in_use > MAX_BOUND) ? MAX_BOUND : i_groups_in_use;
    assign links_ext  = gcw_pkg::GIU_W'(r_links);
    assign count_step = {1'b0, r_count} + (gcw_pkg::COUNT_W + 1)'(i_sectors_per_group);
    assign used_next  = r_is_file ? r_used + gcw_pkg::TOTAL_W'(r_count) : r_used;

    assign o_sts.pos_eq_last = (r_pos == r_last);
    assign o_sts.pos_zero    = (r_pos == '0);
    assign o_sts.at_bound    = (links_ext >= bound);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos     <= (i_req_type == gcw_pkg::REQ_FREE) ? '0 : i_first_group;
            r_last    <= i_last_group;
            r_lsi     <= i_last_sector_index;
            r_is_file <= (i_req_type == gcw_pkg::REQ_FILE);
            r_links   <= '0;
            r_count   <= '0;
            r_status  <= gcw_pkg::ST_OK;
        end else begin
            if (i_cmd.take_link) begin
                r_pos <= rd_data;
            end
            if (i_cmd.step) begin
                r_links <= r_links + 1'b1;
                r_count <= count_step[gcw_pkg::COUNT_W-1:0];
            end else if (i_cmd.add_last) begin
                r_count <= r_count + gcw_pkg::COUNT_W'(r_lsi);
            end
            if (i_cmd.set_over) begin
                r_status <= gcw_pkg::ST_TOO_MANY;
            end else if (i_cmd.set_end) begin
                r_status <= (rd_data != '0) ? gcw_pkg::ST_LAST_NZ : gcw_pkg::ST_OK;
            end
        end
        if (i_cmd.emit) begin
            r_out_count  <= r_count;
            r_out_status <= r_status;
            r_out_total  <= used_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_used      <= used_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_sector_count       = r_out_count;
    assign o_chain_status       = r_out_status;
    assign o_used_sectors_total = r_out_total;

`ifndef SYNTHESIS
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result register not loaded on hand-off");

    a_link_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_link |-> $past(i_cmd.rd_en))
        else $error("link taken without a table read the cycle before");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

@@ src/group_chain_walker_unit.sv @@
// Top level: allocation-table chain walker with APB configuration registers.
// One request is worked at a time; the next request is taken once the
// previous result sits in the output register. A table write or an unused
// request type goes straight to the hand-off. A file query follows links
// until last_group or the link cap; a free-space query starts at group 0
// and follows links until a zero link or the cap. Each link costs one
// table read through the registered RAM port and one check of the
// returned link. Walks are capped at the smaller of groups_in_use and
// MAX_GROUPS links. Registers: 0x0 sectors_per_group (reset 2),
// 0x4 groups_in_use (reset 200).
module group_chain_walker_unit #(
    parameter int unsigned MAX_GROUPS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcw_req_if.sink     i_req,
    gcw_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic CFG_SPG = 1'b0;
    localparam logic CFG_GIU = 1'b1;

    logic [gcw_pkg::SPG_W-1:0] r_sectors_per_group;
    logic [gcw_pkg::GIU_W-1:0] r_groups_in_use;
    logic                      cfg_wr;
    gcw_pkg::t_cmd             cmd;
    gcw_pkg::t_sts             sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sectors_per_group <= gcw_pkg::SPG_W'(2);
            r_groups_in_use     <= gcw_pkg::GIU_W'(200);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_SPG: r_sectors_per_group <= pwdata[gcw_pkg::SPG_W-1:0];
                CFG_GIU: r_groups_in_use     <= pwdata[gcw_pkg::GIU_W-1:0];
                default: r_groups_in_use     <= r_groups_in_use;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_SPG: prdata = 32'(r_sectors_per_group);
            CFG_GIU: prdata = 32'(r_groups_in_use);
            default: prdata = '0;
        endcase
    end

    gcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    gcw_dp #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_req_type           (i_req.req_type),
        .i_entry_index        (i_req.entry_index),
        .i_entry_value        (i_req.entry_value),
        .i_first_group        (i_req.first_group),
        .i_last_group         (i_req.last_group),
        .i_last_sector_index  (i_req.last_sector_index),
        .i_sectors_per_group  (r_sectors_per_group),
        .i_groups_in_use      (r_groups_in_use),
        .i_out_ready          (o_rsp.ready),
        .o_out_valid          (o_rsp.valid),
        .o_sector_count       (o_rsp.sector_count),
        .o_chain_status       (o_rsp.chain_status),
        .o_used_sectors_total (o_rsp.used_sectors_total)
    );

endmodule
